/* rtl/bra_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_pkg - shared types and constants of the bitmap run allocator
// Map geometry, request codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bra_pkg;

    localparam int MAP_BITS  = 1024;
    localparam int BYTE_W    = 8;
    localparam int MAP_BYTES = MAP_BITS / BYTE_W;
    localparam int BYTE_AW   = $clog2(MAP_BYTES);
    localparam int BIT_AW    = $clog2(BYTE_W);
    localparam int PTR_W     = BYTE_AW + 1;
    localparam int IDX_W     = 10;
    localparam int LEN_W     = 11;
    localparam int CFG_W     = 8;
    localparam int OP_W      = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    localparam logic [CFG_W-1:0] MAP_BYTES_RESET = 8'd128;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_TEST  = 2'd1,
        OP_WRITE = 2'd2,
        OP_SCAN  = 2'd3
    } op_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic rd;
        logic test;
        logic wr;
        logic scan_run;
        logic out_load;
    } bra_cmd_t;

    typedef struct packed {
        op_t  in_op;
        logic in_len_ok;
        op_t  req_op;
        logic scan_hit;
        logic scan_end;
        logic out_free;
    } bra_sts_t;

endpackage

/* rtl/bra_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_ctrl - request sequencer
// One-hot state machine that takes one request at a time and steps the
// datapath through clear, read-modify-write, test and scan.
// ----------------------------------------------------------------------------
module bra_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  bra_pkg::bra_sts_t sts,
    output bra_pkg::bra_cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLEAR = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_TEST  = 7'b0001000,
        ST_WRITE = 7'b0010000,
        ST_SCAN  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.start = 1'b1;
                    case (sts.in_op)
                        bra_pkg::OP_CLEAR: state_next = ST_CLEAR;
                        bra_pkg::OP_TEST:  state_next = ST_READ;
                        bra_pkg::OP_WRITE: state_next = ST_READ;
                        default:           state_next = sts.in_len_ok ? ST_SCAN : ST_DONE;
                    endcase
                end
            end
            ST_CLEAR: begin
                cmd.clear  = 1'b1;
                state_next = ST_DONE;
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = (sts.req_op == bra_pkg::OP_TEST) ? ST_TEST : ST_WRITE;
            end
            ST_TEST: begin
                cmd.test   = 1'b1;
                state_next = ST_DONE;
            end
            ST_WRITE: begin
                cmd.wr     = 1'b1;
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_hit || sts.scan_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    // one request in flight: an accepted word closes the input until done
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> !in_ready)
        else $error("bra_ctrl: input reopened right after accept");
`endif

endmodule

/* rtl/bra_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_datapath - map storage, scan unit and result register
// Byte-wide map memory with per-byte valid bits, run counter for the
// first-fit scan, request and result registers, output register.
// ----------------------------------------------------------------------------
module bra_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [bra_pkg::IN_DATA_W-1:0]    in_tdata,
    input  logic [bra_pkg::OP_W-1:0]         in_tuser,
    input  logic                             cfg_valid,
    input  logic [bra_pkg::CFG_W-1:0]        cfg_data,
    input  bra_pkg::bra_cmd_t                cmd,
    output bra_pkg::bra_sts_t                sts,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bra_pkg::OUT_DATA_W-1:0]   m_tdata
);

    // map storage
    logic [bra_pkg::BYTE_W-1:0]    mem [bra_pkg::MAP_BYTES];
    logic [bra_pkg::MAP_BYTES-1:0] vld_reg, vld_next;
    logic [bra_pkg::BYTE_W-1:0]    rd_data_reg;
    logic                          rd_vld_reg;
    logic [bra_pkg::BYTE_W-1:0]    rd_eff;
    logic [bra_pkg::BYTE_AW-1:0]   rd_addr;
    logic                          rd_en;
    logic [bra_pkg::BYTE_W-1:0]    wr_byte;

    // configuration
    logic [bra_pkg::CFG_W-1:0]     map_bytes_reg;
    logic [bra_pkg::PTR_W-1:0]     bytes_use;
    logic [bra_pkg::LEN_W-1:0]     bits_use;

    // request
    bra_pkg::op_t                  op_reg;
    logic [bra_pkg::IDX_W-1:0]     idx_reg;
    logic                          val_reg;
    logic [bra_pkg::LEN_W-1:0]     len_reg;
    logic [bra_pkg::LEN_W-1:0]     in_len;

    // scan
    logic [bra_pkg::PTR_W-1:0]     ptr_reg;
    logic [bra_pkg::PTR_W-1:0]     dptr_reg;
    logic                          pend_reg;
    logic [bra_pkg::LEN_W-1:0]     cnt_reg;
    logic [bra_pkg::LEN_W-1:0]     run;
    logic                          byte_hit;
    logic [bra_pkg::BIT_AW-1:0]    hit_pos;
    logic [bra_pkg::IDX_W-1:0]     hit_bit;
    logic [bra_pkg::LEN_W-1:0]     hit_start;
    logic                          scan_issue;

    // result
    logic                          found_reg;
    logic [bra_pkg::IDX_W-1:0]     start_reg;
    logic                          state_reg;
    logic                          m_tvalid_reg;
    logic [bra_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    // ---------------------------------------------------------------------
    // limits
    // ---------------------------------------------------------------------
    always_comb begin
        if (map_bytes_reg > bra_pkg::CFG_W'(bra_pkg::MAP_BYTES)) begin
            bytes_use = bra_pkg::PTR_W'(bra_pkg::MAP_BYTES);
        end else begin
            bytes_use = bra_pkg::PTR_W'(map_bytes_reg);
        end
    end

    assign bits_use = bra_pkg::LEN_W'({bytes_use, {bra_pkg::BIT_AW{1'b0}}});
    assign in_len   = in_tdata[bra_pkg::IDX_W+1 +: bra_pkg::LEN_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_bytes_reg <= bra_pkg::MAP_BYTES_RESET;
        end else if (cfg_valid) begin
            map_bytes_reg <= cfg_data;
        end
    end

    // ---------------------------------------------------------------------
    // memory: one read or one write per cycle, registered read
    // ---------------------------------------------------------------------
    assign scan_issue = cmd.scan_run && (ptr_reg < bytes_use);
    assign rd_en      = cmd.rd || scan_issue;
    assign rd_addr    = cmd.scan_run ? ptr_reg[bra_pkg::BYTE_AW-1:0]
                                     : idx_reg[bra_pkg::IDX_W-1:bra_pkg::BIT_AW];
    assign rd_eff     = rd_vld_reg ? rd_data_reg : '0;

    always_comb begin
        wr_byte = rd_eff;
        wr_byte[idx_reg[bra_pkg::BIT_AW-1:0]] = val_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            mem[idx_reg[bra_pkg::IDX_W-1:bra_pkg::BIT_AW]] <= wr_byte;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // clear drops the valid bit of every byte in use; bytes above stay
    always_comb begin
        vld_next = vld_reg;
        if (cmd.clear) begin
            for (int i = 0; i < bra_pkg::MAP_BYTES; i++) begin
                if (bra_pkg::PTR_W'(i) < bytes_use) begin
                    vld_next[i] = 1'b0;
                end
            end
        end
        if (cmd.wr) begin
            vld_next[idx_reg[bra_pkg::IDX_W-1:bra_pkg::BIT_AW]] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // ---------------------------------------------------------------------
    // scan: extend the free run over one byte, lowest bit first
    // ---------------------------------------------------------------------
    always_comb begin
        run      = cnt_reg;
        byte_hit = 1'b0;
        hit_pos  = '0;
        for (int j = 0; j < bra_pkg::BYTE_W; j++) begin
            if (rd_eff[j]) begin
                run = '0;
            end else begin
                run = run + 1'b1;
            end
            if (!byte_hit && (run == len_reg)) begin
                byte_hit = 1'b1;
                hit_pos  = bra_pkg::BIT_AW'(j);
            end
        end
    end

    assign hit_bit   = {dptr_reg[bra_pkg::BYTE_AW-1:0], hit_pos};
    assign hit_start = bra_pkg::LEN_W'(hit_bit) + 1'b1 - len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else if (cmd.start) begin
            pend_reg <= 1'b0;
        end else if (cmd.scan_run) begin
            pend_reg <= scan_issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            ptr_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.scan_run) begin
            if (scan_issue) begin
                ptr_reg  <= ptr_reg + 1'b1;
                dptr_reg <= ptr_reg;
            end
            if (pend_reg) begin
                cnt_reg <= run;
            end
        end
    end

    // ---------------------------------------------------------------------
    // request and result registers
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg  <= bra_pkg::op_t'(in_tuser);
            idx_reg <= in_tdata[bra_pkg::IDX_W-1:0];
            val_reg <= in_tdata[bra_pkg::IDX_W];
            len_reg <= in_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
            start_reg <= '0;
            state_reg <= 1'b0;
        end else if (cmd.start) begin
            found_reg <= 1'b0;
            start_reg <= '0;
            state_reg <= 1'b0;
        end else if (cmd.test) begin
            state_reg <= rd_eff[idx_reg[bra_pkg::BIT_AW-1:0]];
        end else if (cmd.scan_run && pend_reg && byte_hit) begin
            found_reg <= 1'b1;
            start_reg <= hit_start[bra_pkg::IDX_W-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= bra_pkg::OUT_DATA_W'({state_reg, start_reg, found_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------------
    // status
    // ---------------------------------------------------------------------
    assign sts.in_op     = bra_pkg::op_t'(in_tuser);
    assign sts.in_len_ok = (in_len != '0) && (in_len <= bits_use);
    assign sts.req_op    = op_reg;
    assign sts.scan_hit  = pend_reg && byte_hit;
    assign sts.scan_end  = !pend_reg && (ptr_reg == bytes_use);
    assign sts.out_free  = !m_tvalid_reg || m_tready;

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("bra_datapath: result loaded over an unsent word");

    a_no_start_unless_found: assert property (@(posedge aclk) disable iff (!aresetn)
        !found_reg |-> (start_reg == '0))
        else $error("bra_datapath: start index set without a hit");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan_run && pend_reg) |-> (dptr_reg < bytes_use))
        else $error("bra_datapath: scan read a byte beyond the map in use");

    a_hit_in_map: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan_run && pend_reg && byte_hit) |-> (bra_pkg::LEN_W'(hit_bit) < bits_use))
        else $error("bra_datapath: run ends outside the map in use");
`endif

endmodule

/* rtl/bitmap_run_allocator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_run_allocator_unit - first-fit allocation bitmap
// Keeps a 1024-bit usage map (1 = used) and serves clear-all, test-bit,
// write-bit and scan-for-free-run requests, one result word per request.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tuser op, s_tdata request fields
// m_        out        m_tvalid/m_tready  m_tdata result fields
// cfg_      in         cfg_valid/ready    cfg_data map_bytes
//
// Test and write first read the addressed byte through the one map port; write
// then modifies it. A scan walks one byte per cycle and stops on the first
// fitting run, and answers without a walk when its length is 0 or exceeds the map.
// Reset: synchronous, active low; the map reads as all free, map_bytes is 128.
// Work one request at a time; take the next once its result sits in the output
// register, even with m_tready low, and hold it in its final step on a stall.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bra_pkg::IN_DATA_W-1:0]   s_tdata,   // bit_index[9:0], bit_value[10],
                                                       // run_length[21:11], zero[23:22]
    input  logic [bra_pkg::OP_W-1:0]        s_tuser,   // op[1:0]
    // result
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bra_pkg::OUT_DATA_W-1:0]  m_tdata,   // found[0], start_index[10:1],
                                                       // bit_state[11], zero[15:12]
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bra_pkg::CFG_W-1:0]       cfg_data   // map_bytes[7:0]
);

    bra_pkg::bra_cmd_t cmd;
    bra_pkg::bra_sts_t sts;

    // register writes must arrive only while idle, which the block does not enforce: always take them
    assign cfg_ready = 1'b1;

    bra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bra_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_tdata  (s_tdata),
        .in_tuser  (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the bitmap run allocator
// Drives clear, test, write and scan requests, including allocation-style
// sequences that mark some runs the scans find. A scoreboard keeps its own copy
// of the usage map and the map size and checks every result word field by
// field. Handshake pacing changes between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import bra_pkg::*;

    localparam int STALL_LIMIT = 4000;   // cycles with no handshake at all
    localparam int TAIL_CYCLES = 200;    // idle tail after the drain

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] start;
        logic             bit_state;
    } alloc_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow usage map, map size and queue of expected results
    // ------------------------------------------------------------------------
    class alloc_scoreboard;
        logic [MAP_BITS-1:0] usage;
        logic [CFG_W-1:0]    map_bytes;
        alloc_result_t       pending_results[$];
        int                  errors;
        int                  requests;
        int                  checked;
        int                  scan_hits;
        int                  scan_misses;

        function new();
            usage       = '0;
            map_bytes   = MAP_BYTES_RESET;
            errors      = 0;
            requests    = 0;
            checked     = 0;
            scan_hits   = 0;
            scan_misses = 0;
        endfunction

        // sizes above the map clamp to the whole map
        function int bits_in_use();
            int nbytes;
            nbytes = (int'(map_bytes) > MAP_BYTES) ? MAP_BYTES : int'(map_bytes);
            return nbytes * BYTE_W;
        endfunction

        function alloc_result_t note_request(op_t op, logic [IDX_W-1:0] idx, logic val,
                                             logic [LEN_W-1:0] len);
            alloc_result_t r;
            int            limit;
            int            run;
            r     = '0;
            limit = bits_in_use();
            requests++;
            case (op)
                OP_CLEAR: begin
                    // only the bytes in use are cleared
                    for (int i = 0; i < limit; i++) usage[i] = 1'b0;
                end
                OP_TEST:  r.bit_state = usage[idx];
                OP_WRITE: usage[idx] = val;
                default: begin
                    // first fit; zero length or too long a run never fits
                    run = 0;
                    if (len != 0 && int'(len) <= limit) begin
                        for (int i = 0; i < limit && !r.found; i++) begin
                            run = usage[i] ? 0 : run + 1;
                            if (run == int'(len)) begin
                                r.found = 1'b1;
                                r.start = IDX_W'(i + 1 - run);
                            end
                        end
                    end
                    if (r.found) scan_hits++;
                    else         scan_misses++;
                end
            endcase
            pending_results.push_back(r);
            return r;
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] word);
            alloc_result_t want;
            alloc_result_t got;
            got.found     = word[0];
            got.start     = word[10:1];
            got.bit_state = word[11];
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result word %h with nothing expected", $time, word);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.found !== want.found) begin
                errors++;
                $display("%0t: found mismatch, expected %0d, actual %0d",
                         $time, want.found, got.found);
            end
            if (got.start !== want.start) begin
                errors++;
                $display("%0t: start_index mismatch, expected %0d, actual %0d",
                         $time, want.start, got.start);
            end
            if (got.bit_state !== want.bit_state) begin
                errors++;
                $display("%0t: bit_state mismatch, expected %0d, actual %0d",
                         $time, want.bit_state, got.bit_state);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports; every input is known from time zero
    // ------------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // bit_index[9:0], bit_value[10],
                                             // run_length[21:11], zero[23:22]
    logic [OP_W-1:0]       s_tuser   = '0;   // op[1:0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // found[0], start_index[10:1],
                                             // bit_state[11], zero[15:12]
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data  = '0;   // map_bytes[7:0]

    alloc_scoreboard sb;
    int              src_idle_pct  = 13;
    int              sink_idle_pct = 80;
    int              quiet_cycles  = 0;
    int              cfg_writes    = 0;

    always #2 aclk = ~aclk;

    bitmap_run_allocator_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Request driver: idle at random, then hold the word until it is taken.
    // Valid is only lowered in idle cycles, so back-to-back words never see
    // a low and a high assignment in the same step.
    // ------------------------------------------------------------------------
    task automatic send_request(input op_t op, input logic [IDX_W-1:0] idx,
                                input logic val, input logic [LEN_W-1:0] len,
                                output alloc_result_t r);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, len, val, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = sb.note_request(op, idx, val, len);
    endtask

    // Change map size only once every expected word has come back; every
    // request yields a word, so an empty queue means the block is idle.
    task automatic write_map_bytes(input logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.map_bytes = value;
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Result sink: check each taken word, then pick the next ready level
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Watchdog: end the run when nothing moves on any channel for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("tb_top: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        alloc_result_t    r;
        alloc_result_t    w;
        op_t              op;
        logic [IDX_W-1:0] idx;
        logic             val;
        logic [LEN_W-1:0] len;
        logic [CFG_W-1:0] size;
        int               limit;
        int               pick;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes on the full map
        send_request(OP_TEST,  10'd0,    1'b0, 11'd0,    r);
        send_request(OP_TEST,  10'd1023, 1'b1, 11'd2047, r);
        send_request(OP_SCAN,  10'd1023, 1'b1, 11'd0,    r);   // zero length
        send_request(OP_SCAN,  10'd0,    1'b0, 11'd1024, r);   // whole map free
        send_request(OP_SCAN,  10'd0,    1'b0, 11'd1025, r);   // longer than the map
        send_request(OP_SCAN,  10'd0,    1'b0, 11'd2047, r);
        send_request(OP_WRITE, 10'd0,    1'b1, 11'd0,    r);
        send_request(OP_WRITE, 10'd1023, 1'b1, 11'd2047, r);
        send_request(OP_TEST,  10'd1023, 1'b0, 11'd0,    r);
        send_request(OP_SCAN,  10'd0,    1'b0, 11'd1022, r);   // fits between the ends
        send_request(OP_SCAN,  10'd0,    1'b0, 11'd1023, r);
        send_request(OP_WRITE, 10'd1023, 1'b0, 11'd0,    r);
        send_request(OP_SCAN,  10'd0,    1'b0, 11'd1023, r);   // run reaches the last bit
        send_request(OP_CLEAR, 10'd1023, 1'b1, 11'd2047, r);

        // Smallest map: clear leaves bits above the bytes in use alone
        write_map_bytes(8'd1);
        send_request(OP_WRITE, 10'd8,    1'b1, 11'd0,    r);
        send_request(OP_WRITE, 10'd3,    1'b1, 11'd0,    r);
        send_request(OP_SCAN,  10'd0,    1'b0, 11'd4,    r);
        send_request(OP_SCAN,  10'd0,    1'b0, 11'd5,    r);
        send_request(OP_SCAN,  10'd0,    1'b0, 11'd9,    r);
        send_request(OP_CLEAR, 10'd0,    1'b0, 11'd0,    r);
        send_request(OP_TEST,  10'd8,    1'b0, 11'd0,    r);

        // Oversized setting clamps to the whole map
        write_map_bytes(8'd255);
        send_request(OP_SCAN,  10'd0,    1'b0, 11'd1015, r);
        send_request(OP_SCAN,  10'd0,    1'b0, 11'd1016, r);

        // No bytes in use: nothing fits and clear touches nothing
        write_map_bytes(8'd0);
        send_request(OP_SCAN,  10'd0,    1'b0, 11'd1,    r);
        send_request(OP_CLEAR, 10'd0,    1'b0, 11'd0,    r);
        send_request(OP_TEST,  10'd8,    1'b0, 11'd0,    r);

        // Random: three pacing phases, six map sizes in each
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct  = (ph == 0) ? 13 : (ph == 1) ? 80 : 0;
            sink_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 13 : 0;
            for (int blk = 0; blk < 6; blk++) begin
                case (blk)
                    0:       size = 8'd128;
                    1:       size = CFG_W'($urandom_range(1, 16));
                    2:       size = 8'd255;
                    3:       size = CFG_W'($urandom_range(17, 127));
                    4:       size = (ph == 0) ? 8'd0 : CFG_W'($urandom_range(129, 254));
                    default: size = 8'd1;
                endcase
                write_map_bytes(size);
                limit = sb.bits_in_use();
                for (int n = 0; n < 42; n++) begin
                    // unused fields carry noise
                    idx  = IDX_W'($urandom_range(0, MAP_BITS - 1));
                    val  = 1'($urandom_range(0, 1));
                    len  = LEN_W'($urandom_range(0, 2047));
                    if (limit > 0 && $urandom_range(0, 4) != 0)
                        idx = IDX_W'($urandom_range(0, limit - 1));
                    pick = $urandom_range(0, 99);
                    if (pick < 4) begin
                        op = OP_CLEAR;
                    end else if (pick < 40) begin
                        op  = OP_WRITE;
                        val = ($urandom_range(0, 99) < 70);
                    end else if (pick < 60) begin
                        op = OP_TEST;
                    end else begin
                        op   = OP_SCAN;
                        pick = $urandom_range(0, 19);
                        if (pick < 13)
                            len = LEN_W'($urandom_range(1, 24));
                        else if (pick < 16 && limit > 0)
                            len = LEN_W'($urandom_range(1, limit));
                        else if (pick < 18)
                            len = LEN_W'(limit + $urandom_range(0, 1));
                    end
                    send_request(op, idx, val, len, r);
                    // allocate: mark a short run that was found, as a caller would
                    if (op == OP_SCAN && r.found && len <= 24 && $urandom_range(0, 1)) begin
                        for (int k = 0; k < int'(len); k++)
                            send_request(OP_WRITE, IDX_W'(r.start + k), 1'b1,
                                         LEN_W'($urandom_range(0, 2047)), w);
                    end
                end
            end
        end

        // Drain every expected result word, then idle for a tail
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("tb_top: %0d requests, %0d result words checked, %0d scans hit, %0d missed",
                 sb.requests, sb.checked, sb.scan_hits, sb.scan_misses);
        $display("tb_top: %0d map size writes from 0 to 255 bytes over three pacing phases",
                 cfg_writes);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/bra_pkg.sv
rtl/bra_ctrl.sv
rtl/bra_datapath.sv
rtl/bitmap_run_allocator_unit.sv
tb/tb_top.sv
